@@ src/bfu_pkg.sv @@
// Shared widths, register codes and types of the binary frame bit unpacker.
// Used by the channel interfaces, the front queue, the back engine and the top level.
// No dependencies.
package bfu_pkg;

	localparam int BYTE_W       = 8;
	localparam int FRAME_BITS_W = 24;
	localparam int FRAME_CNT_W  = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 24;

	// Bit position and fill count inside one byte, and a bit count up to eight
	localparam int POS_W   = 3;
	localparam int AVAIL_W = 4;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd1;

	// Register reset values
	localparam logic [FRAME_BITS_W-1:0] FRAME_BITS_RST  = 24'd1;
	localparam logic [FRAME_CNT_W-1:0]  FRAME_COUNT_RST = 16'd1;

	typedef struct packed {
		logic [FRAME_BITS_W-1:0] frame_bits;
		logic [FRAME_CNT_W-1:0]  frame_count;
	} cfg_t;

	typedef struct packed {
		logic                   we;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_DATA_W-1:0]  wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} q_head_t;

endpackage

@@ src/bfu_in_if.sv @@
// Input channel of the unpacker: one packed stream byte per request.
// Depends on bfu_pkg for the byte width.
interface bfu_in_if;
	logic                        valid;
	logic                        ready;
	logic [bfu_pkg::BYTE_W-1:0]  packed_byte;

	modport source(output valid, output packed_byte, input ready);
	modport sink(input valid, input packed_byte, output ready);
endinterface

@@ src/bfu_out_if.sv @@
// Output channel of the unpacker: one aligned frame byte with its tags per request.
// Depends on bfu_pkg for the field widths.
interface bfu_out_if;
	logic                             valid;
	logic                             ready;
	logic [bfu_pkg::BYTE_W-1:0]       out_byte;
	logic [bfu_pkg::FRAME_CNT_W-1:0]  frame_number;
	logic                             frame_end;
	logic                             all_done;
	logic                             run_last;

	modport source(output valid, output out_byte, output frame_number, output frame_end,
		output all_done, output run_last, input ready);
	modport sink(input valid, input out_byte, input frame_number, input frame_end,
		input all_done, input run_last, output ready);
endinterface

@@ src/binary_frame_bit_unpacker_core.sv @@
// Top level of the binary frame bit unpacker: configuration registers, front queue
// and back engine. Depends on bfu_pkg, bfu_in_if, bfu_out_if, bfu_front and bfu_back.
//
// Usage:
//   in_ch carries packed stream bytes, frame_bits-bit frames packed back to back, bit 0 first.
//   out_ch carries each frame as aligned bytes, top bits of the last byte zero,
//   tagged with frame_number, frame_end, all_done, and run_last on the last byte
//   that one input byte produced.
//   cfg_we/cfg_index/cfg_wdata write frame_bits (index 0) or frame_count (index 1);
//   each write restarts the stream. Write only while the block is idle.
// Timing:
//   A request taken from in_ch passes the queue, the current-byte register and the
//   output register before its first result shows on out_ch. The back engine handles
//   one output byte per cycle while out_ch takes its results, and holds an input byte
//   until it has yielded all of them: one byte a cycle when frame_bits is a multiple
//   of eight, a step for each result otherwise, and a result per bit for one-bit frames.
//   A four-entry queue lets in_ch keep taking bytes while the engine works.
// Reset and stall:
//   arst_n clears the queue and output and sets both registers to one.
//   A stalled out_ch holds its result; the engine stops, the queue fills, and then
//   in_ch.ready drops. After the last frame, further input bytes are taken and dropped.
module binary_frame_bit_unpacker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	bfu_in_if.sink                            in_ch,
	bfu_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [bfu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	bfu_pkg::cfg_t     cfg;
	bfu_pkg::cfg_wr_t  wr;
	bfu_pkg::q_head_t  q_head;
	logic              q_pop;
	logic              finished;

	logic [bfu_pkg::FRAME_BITS_W-1:0] frame_bits_q;
	logic [bfu_pkg::FRAME_CNT_W-1:0]  frame_count_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bits_q  <= bfu_pkg::FRAME_BITS_RST;
			frame_count_q <= bfu_pkg::FRAME_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bfu_pkg::REG_FRAME_BITS: begin
					frame_bits_q <= cfg_wdata[bfu_pkg::FRAME_BITS_W-1:0];
				end
				bfu_pkg::REG_FRAME_COUNT: begin
					frame_count_q <= cfg_wdata[bfu_pkg::FRAME_CNT_W-1:0];
				end
				default: begin
					frame_bits_q <= frame_bits_q;
				end
			endcase
		end
	end

	assign cfg.frame_bits  = frame_bits_q;
	assign cfg.frame_count = frame_count_q;
	assign wr.we           = cfg_we;
	assign wr.index        = cfg_index;
	assign wr.wdata        = cfg_wdata;

	bfu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.finished (finished),
		.head     (q_head),
		.pop      (q_pop)
	);

	bfu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.wr       (wr),
		.head     (q_head),
		.pop      (q_pop),
		.finished (finished),
		.out_ch   (out_ch)
	);

`ifndef ASSERT_OFF
	// The byte that ends the last frame ends its frame and its input byte's run
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.all_done |-> out_ch.frame_end && out_ch.run_last)
		else $error("all_done without frame_end or run_last");

	// Nothing follows the last frame
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.all_done |=> !out_ch.valid)
		else $error("result after the last frame");

	// The engine pulls only from a non-empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("queue popped while empty");
`endif

endmodule

@@ src/bfu_front.sv @@
// Front of the unpacker: accepts stream bytes, drops those that cannot produce
// output, and holds the rest in a short queue. Depends on bfu_pkg and bfu_in_if.
module bfu_front (
	input  logic                   clk,
	input  logic                   arst_n,
	bfu_in_if.sink                 in_ch,
	input  bfu_pkg::cfg_t          cfg,
	input  logic                   finished,
	output bfu_pkg::q_head_t       head,
	input  logic                   pop
);

	logic [bfu_pkg::BYTE_W-1:0]      mem_q [bfu_pkg::QUEUE_DEPTH];
	logic [bfu_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [bfu_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [bfu_pkg::QUEUE_CNT_W-1:0] cnt_q;
	logic                            accept;
	logic                            drop;
	logic                            push;

	// Accept whenever a slot is free
	assign in_ch.ready = (cnt_q != bfu_pkg::QUEUE_CNT_W'(bfu_pkg::QUEUE_DEPTH));
	assign accept      = in_ch.valid && in_ch.ready;

	// Drop bytes after completion or under an empty configuration
	assign drop = finished || (cfg.frame_bits == '0) || (cfg.frame_count == '0);
	assign push = accept && !drop;

	// Present the oldest byte
	assign head.valid = (cnt_q != '0);
	assign head.data  = mem_q[rd_ptr_q];

	// Store accepted bytes
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_ch.packed_byte;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/bfu_back.sv @@
// Back of the unpacker: takes queued bytes and emits one aligned frame byte per
// step through an output register. Depends on bfu_pkg and bfu_out_if.
module bfu_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bfu_pkg::cfg_t          cfg,
	input  bfu_pkg::cfg_wr_t       wr,
	input  bfu_pkg::q_head_t       head,
	output logic                   pop,
	output logic                   finished,
	bfu_out_if.source              out_ch
);

	localparam int LPAD = bfu_pkg::FRAME_BITS_W - bfu_pkg::AVAIL_W;

	// Mask of the low n bits, n up to eight
	function automatic logic [bfu_pkg::BYTE_W-1:0] low_mask(input logic [bfu_pkg::AVAIL_W-1:0] n);
		logic [bfu_pkg::BYTE_W:0] m;
		m = ({{bfu_pkg::BYTE_W{1'b0}}, 1'b1} << n) - 1'b1;
		return m[bfu_pkg::BYTE_W-1:0];
	endfunction

	// Current input byte
	logic                              cur_valid_q;
	logic [bfu_pkg::BYTE_W-1:0]        cur_q;
	logic [bfu_pkg::POS_W-1:0]         pos_q;
	// Stream state
	logic [bfu_pkg::BYTE_W-1:0]        partial_q;
	logic [bfu_pkg::POS_W-1:0]         fill_q;
	logic [bfu_pkg::FRAME_BITS_W-1:0]  left_q;
	logic [bfu_pkg::FRAME_CNT_W-1:0]   frame_q;
	logic                              finished_q;
	// Output register
	logic                              ovalid_q;
	logic [bfu_pkg::BYTE_W-1:0]        obyte_q;
	logic [bfu_pkg::FRAME_CNT_W-1:0]   onum_q;
	logic                              oend_q;
	logic                              odone_q;
	logic                              olast_q;

	logic [bfu_pkg::AVAIL_W-1:0]       avail;
	logic [bfu_pkg::AVAIL_W-1:0]       room;
	logic [bfu_pkg::AVAIL_W-1:0]       take;
	logic [bfu_pkg::AVAIL_W-1:0]       rest;
	logic [bfu_pkg::AVAIL_W-1:0]       dec;
	logic                              left_le_avail;
	logic                              left_le_room;
	logic                              is_end;
	logic                              is_full;
	logic                              emit;
	logic                              done;
	logic                              more;
	logic                              tail;
	logic                              out_free;
	logic                              go;
	logic                              byte_done;
	logic                              restart;
	logic [bfu_pkg::BYTE_W-1:0]        bits;
	logic [bfu_pkg::BYTE_W-1:0]        merged;
	logic [bfu_pkg::BYTE_W-1:0]        leftover;
	logic [bfu_pkg::FRAME_CNT_W-1:0]   frame_inc;
	logic [bfu_pkg::FRAME_BITS_W-1:0]  l_base;
	logic [bfu_pkg::FRAME_BITS_W-1:0]  left_next;
	logic [bfu_pkg::FRAME_BITS_W-1:0]  restart_left;

	// Classify the next step: frame end, full byte, or absorb the rest of the byte
	always_comb begin
		avail         = bfu_pkg::AVAIL_W'(bfu_pkg::BYTE_W) - {1'b0, pos_q};
		room          = bfu_pkg::AVAIL_W'(bfu_pkg::BYTE_W) - {1'b0, fill_q};
		left_le_avail = (left_q <= {{LPAD{1'b0}}, avail});
		left_le_room  = (left_q <= {{LPAD{1'b0}}, room});
		is_end        = left_le_avail && left_le_room;
		is_full       = !is_end && (room <= avail);
		emit          = (is_end || is_full) && !finished_q;
		if (is_end) begin
			take = left_q[bfu_pkg::AVAIL_W-1:0];
		end else if (is_full) begin
			take = room;
		end else begin
			take = avail;
		end
		rest      = avail - take;
		bits      = cur_q >> pos_q;
		merged    = partial_q | ((bits & low_mask(take)) << fill_q);
		leftover  = (bits >> take) & low_mask(rest);
		frame_inc = frame_q + 1'b1;
		done      = emit && is_end && (frame_inc == cfg.frame_count);
		// Another frame byte completes inside this input byte
		if (is_end) begin
			more = emit && !done && (rest != '0) &&
				(cfg.frame_bits <= {{LPAD{1'b0}}, rest});
		end else begin
			more = emit && !done && (rest != '0) && left_le_avail;
		end
		tail      = emit && !more && !done && (rest != '0);
		l_base    = is_end ? cfg.frame_bits : left_q;
		dec       = (is_end ? '0 : take) + (tail ? rest : '0);
		left_next = l_base - {{LPAD{1'b0}}, dec};
		byte_done = !more;
	end

	// Step when the result, if any, has room in the output register
	assign out_free = !ovalid_q || out_ch.ready;
	assign go       = cur_valid_q && (finished_q || !emit || out_free);
	assign pop      = head.valid && (!cur_valid_q || (go && byte_done));
	assign finished = finished_q;

	// Decode configuration writes that restart the stream
	always_comb begin
		restart      = 1'b0;
		restart_left = cfg.frame_bits;
		if (wr.we) begin
			case (wr.index)
				bfu_pkg::REG_FRAME_BITS: begin
					restart      = 1'b1;
					restart_left = wr.wdata[bfu_pkg::FRAME_BITS_W-1:0];
				end
				bfu_pkg::REG_FRAME_COUNT: begin
					restart = 1'b1;
				end
				default: begin
					restart = 1'b0;
				end
			endcase
		end
	end

	// Hold the current input byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
		end else if (go && byte_done) begin
			cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.data;
		end
	end

	// Advance the stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			partial_q  <= '0;
			fill_q     <= '0;
			left_q     <= bfu_pkg::FRAME_BITS_RST;
			frame_q    <= '0;
			finished_q <= 1'b0;
		end else if (restart) begin
			pos_q      <= '0;
			partial_q  <= '0;
			fill_q     <= '0;
			left_q     <= restart_left;
			frame_q    <= '0;
			finished_q <= 1'b0;
		end else begin
			if (go && !finished_q) begin
				left_q <= left_next;
				if (emit) begin
					if (is_end) begin
						frame_q <= frame_inc;
					end
					if (done) begin
						finished_q <= 1'b1;
					end
					partial_q <= tail ? leftover : '0;
					fill_q    <= tail ? rest[bfu_pkg::POS_W-1:0] : '0;
					if (more) begin
						pos_q <= pos_q + take[bfu_pkg::POS_W-1:0];
					end
				end else begin
					partial_q <= merged;
					fill_q    <= fill_q + avail[bfu_pkg::POS_W-1:0];
				end
			end
			if (pop) begin
				pos_q <= '0;
			end
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (go && emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			obyte_q <= merged;
			onum_q  <= frame_q;
			oend_q  <= is_end;
			odone_q <= done;
			olast_q <= !more;
		end
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.out_byte     = obyte_q;
	assign out_ch.frame_number = onum_q;
	assign out_ch.frame_end    = oend_q;
	assign out_ch.all_done     = odone_q;
	assign out_ch.run_last     = olast_q;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for binary_frame_bit_unpacker_core: packed frames go in,
// and a local frame unpacker predicts every aligned output byte and its tags.
// Depends on bfu_pkg, bfu_in_if, bfu_out_if and the RTL top level.
`timescale 1ns / 100ps

module tb;

	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_ITEMS  = 100;

	typedef struct packed {
		logic [bfu_pkg::BYTE_W-1:0]      out_byte;
		logic [bfu_pkg::FRAME_CNT_W-1:0] frame_number;
		logic                            frame_end;
		logic                            all_done;
		logic                            run_last;
	} frame_byte_t;

	logic clk;
	logic arst_n;
	logic                           cfg_we;
	logic [bfu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bfu_pkg::CFG_DATA_W-1:0] cfg_wdata;

	bfu_in_if  in_ch();
	bfu_out_if out_ch();

	binary_frame_bit_unpacker_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Expected frame bytes, oldest first
	frame_byte_t frame_bytes_due[$];
	int error_count = 0;

	// Idle rates and the receiver hold-off request
	int src_idle_pct  = 20;
	int sink_idle_pct = 20;
	int hold_len      = 0;
	bit hold_go       = 0;
	bit hold_seen     = 0;
	int hold_left     = 0;

	// Mirror of the registers and of the unpacking state
	logic [bfu_pkg::FRAME_BITS_W-1:0] frame_bits_cfg;
	logic [bfu_pkg::FRAME_CNT_W-1:0]  frame_count_cfg;
	logic [bfu_pkg::BYTE_W-1:0]       asm_byte;
	logic [bfu_pkg::AVAIL_W-1:0]      asm_fill;
	logic [bfu_pkg::FRAME_BITS_W-1:0] bits_due;
	logic [bfu_pkg::FRAME_CNT_W-1:0]  frame_idx;
	bit                               stream_done;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic report_failure(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic restart_unpacker();
		asm_byte    = '0;
		asm_fill    = '0;
		bits_due    = frame_bits_cfg;
		frame_idx   = '0;
		stream_done = 1'b0;
	endtask

	// Predict the frame bytes that one accepted stream byte yields
	task automatic unpack_byte(input logic [bfu_pkg::BYTE_W-1:0] value);
		frame_byte_t pend;
		frame_byte_t fresh;
		bit have_pend;
		logic [bfu_pkg::FRAME_CNT_W-1:0] next_idx;
		int k;
		have_pend = 1'b0;
		// Ignore input after completion or under an empty configuration
		if (stream_done || frame_bits_cfg == '0 || frame_count_cfg == '0)
			return;
		for (k = 0; k < bfu_pkg::BYTE_W && !stream_done; k++) begin
			asm_byte[asm_fill[bfu_pkg::POS_W-1:0]] = value[k];
			asm_fill = asm_fill + 1'b1;
			bits_due = bits_due - 1'b1;
			if (bits_due == '0) begin
				next_idx = frame_idx + 1'b1;
				fresh = '{asm_byte, frame_idx, 1'b1, next_idx == frame_count_cfg, 1'b0};
				frame_idx = next_idx;
				stream_done = fresh.all_done;
			end else if (asm_fill == bfu_pkg::AVAIL_W'(bfu_pkg::BYTE_W)) begin
				fresh = '{asm_byte, frame_idx, 1'b0, 1'b0, 1'b0};
			end else begin
				continue;
			end
			if (have_pend)
				frame_bytes_due = {frame_bytes_due, pend};
			pend = fresh;
			have_pend = 1'b1;
			asm_byte = '0;
			asm_fill = '0;
			if (fresh.frame_end)
				bits_due = frame_bits_cfg;
		end
		// Flag the last byte of this request's run
		if (have_pend) begin
			pend.run_last = 1'b1;
			frame_bytes_due = {frame_bytes_due, pend};
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_failure($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
	endtask

	task automatic check_result();
		frame_byte_t want;
		if (frame_bytes_due.size() == 0) begin
			report_failure($sformatf("unexpected result: byte %0h frame %0d",
				out_ch.out_byte, out_ch.frame_number));
			return;
		end
		want = frame_bytes_due.pop_front();
		check_field("out_byte", 16'(out_ch.out_byte), 16'(want.out_byte));
		check_field("frame_number", out_ch.frame_number, want.frame_number);
		check_field("frame_end", 16'(out_ch.frame_end), 16'(want.frame_end));
		check_field("all_done", 16'(out_ch.all_done), 16'(want.all_done));
		check_field("run_last", 16'(out_ch.run_last), 16'(want.run_last));
	endtask

	// Check each accepted result, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			check_result();
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = hold_len;
		end
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Offer one stream byte and wait until the request is taken
	task automatic send_byte(input logic [bfu_pkg::BYTE_W-1:0] value);
		bit idled;
		idled = 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			if (!idled)
				in_ch.valid <= 1'b0;
			idled = 1'b1;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.packed_byte <= value;
		do @(posedge clk); while (!in_ch.ready);
		unpack_byte(value);
	endtask

	// Drop valid, wait for every expected byte, then let dropped requests clear
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bfu_pkg::CFG_IDX_W-1:0] idx,
		input logic [bfu_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bfu_pkg::REG_FRAME_BITS)
			frame_bits_cfg = value[bfu_pkg::FRAME_BITS_W-1:0];
		else
			frame_count_cfg = value[bfu_pkg::FRAME_CNT_W-1:0];
		restart_unpacker();
	endtask

	task automatic set_stream(input int fbits, input int fcount);
		wait_idle();
		write_reg(bfu_pkg::REG_FRAME_BITS, bfu_pkg::CFG_DATA_W'(fbits));
		write_reg(bfu_pkg::REG_FRAME_COUNT, bfu_pkg::CFG_DATA_W'(fcount));
	endtask

	// Reset values: one frame of one bit, then input after completion
	task automatic test_reset_values();
		send_byte(8'h01);
		send_byte(8'hFF);
	endtask

	// Whole-byte frames with all-zero, all-one and mixed content, then input past the last frame
	task automatic test_byte_frames();
		set_stream(8, 3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h5A);
	endtask

	// One-bit frames: eight results per byte, and bits past the last frame
	task automatic test_bit_frames();
		set_stream(1, 8);
		send_byte(8'hB6);
		send_byte(8'hFF);
		set_stream(1, 12);
		send_byte(8'h3C);
		send_byte(8'hFF);
	endtask

	// Frames that straddle bytes, padding, and restart on a register write
	task automatic test_odd_frames();
		set_stream(3, 5);
		send_byte(8'hFF);
		send_byte(8'h7F);
		set_stream(12, 2);
		send_byte(8'hC3);
		send_byte(8'h9E);
		send_byte(8'hF1);
		set_stream(12, 2);
		send_byte(8'h81);
		wait_idle();
		write_reg(bfu_pkg::REG_FRAME_COUNT, bfu_pkg::CFG_DATA_W'(2));
		send_byte(8'h7E);
		send_byte(8'h42);
		send_byte(8'hE7);
	endtask

	// Largest register values: no frame completes, then one-bit frames under the largest frame count
	task automatic test_register_extremes();
		set_stream(24'hFFFFFF, 16'hFFFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h01);
		wait_idle();
		write_reg(bfu_pkg::REG_FRAME_BITS, bfu_pkg::CFG_DATA_W'(1));
		send_byte(8'h69);
		send_byte(8'h96);
	endtask

	// Back-to-back requests with no idling on either side
	task automatic test_full_rate();
		int i;
		set_stream(8, 32);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		for (i = 0; i < 34; i++)
			send_byte(8'($urandom));
		wait_idle();
		src_idle_pct  = 20;
		sink_idle_pct = 20;
	endtask

	// Hold the receiver off while one-bit frames keep the queue full
	task automatic test_output_hold();
		int i;
		set_stream(1, 240);
		src_idle_pct = 0;
		hold_len = 150;
		hold_go  = ~hold_go;
		for (i = 0; i < 30; i++)
			send_byte(8'($urandom));
		src_idle_pct = 20;
	endtask

	// Random frame shapes; mostly complete streams, some cut short
	task automatic test_random_streams();
		int taken;
		int fbits;
		int fcount;
		int needed;
		int n;
		int pick;
		int i;
		taken = 0;
		while (taken < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 60)
				fbits = $urandom_range(1, 20);
			else if (pick < 85)
				fbits = $urandom_range(21, 100);
			else
				fbits = $urandom_range(101, 300);
			// Write one register or both, in either order; keep streams short
			pick = $urandom_range(3);
			if (pick == 1)
				fbits = int'(frame_bits_cfg);
			if (pick == 2) begin
				fcount = int'(frame_count_cfg);
				if (fbits * fcount > 320)
					fbits = (320 / fcount > 0) ? 320 / fcount : 1;
			end else begin
				fcount = $urandom_range(1, (320 / fbits > 0) ? 320 / fbits : 1);
			end
			wait_idle();
			if (pick != 1)
				write_reg(bfu_pkg::REG_FRAME_BITS, bfu_pkg::CFG_DATA_W'(fbits));
			if (pick != 2)
				write_reg(bfu_pkg::REG_FRAME_COUNT, bfu_pkg::CFG_DATA_W'(fcount));
			if (pick == 3)
				write_reg(bfu_pkg::REG_FRAME_BITS, bfu_pkg::CFG_DATA_W'(fbits));
			needed = (fbits * fcount + 7) / 8;
			if ($urandom_range(99) < 80)
				n = needed + $urandom_range(0, 3);
			else
				n = $urandom_range(1, needed);
			for (i = 0; i < n; i++)
				send_byte(8'($urandom));
			taken += (n < needed) ? n : needed;
		end
	endtask

	initial begin
		int waited;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = bfu_pkg::REG_FRAME_BITS;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.packed_byte = '0;
		out_ch.ready      = 1'b0;
		frame_bits_cfg    = bfu_pkg::FRAME_BITS_RST;
		frame_count_cfg   = bfu_pkg::FRAME_COUNT_RST;
		restart_unpacker();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_byte_frames();
		test_bit_frames();
		test_odd_frames();
		test_register_extremes();
		test_full_rate();
		test_output_hold();
		test_random_streams();

		// Drain the remaining results, then report what never came
		in_ch.valid <= 1'b0;
		waited = 0;
		while (frame_bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (frame_bytes_due.size() != 0) begin
			report_failure($sformatf("missing result: frame %0d byte %0h",
				frame_bytes_due[0].frame_number, frame_bytes_due[0].out_byte));
			void'(frame_bytes_due.pop_front());
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/bfu_pkg.sv
src/bfu_in_if.sv
src/bfu_out_if.sv
src/bfu_front.sv
src/bfu_back.sv
src/binary_frame_bit_unpacker_core.sv
tb/sv/tb.sv
